@@ rtl/core/lcdfb_pkg.sv @@
`timescale 1ns / 1ps

package lcdfb_pkg;

   // Default geometry of the panel
   localparam int COLUMNS_DEF = 96;
   localparam int ROWS_DEF    = 68;
   localparam int PAGES_DEF   = 9;

   // Request field widths
   localparam int CMD_W     = 3;
   localparam int COORD_W   = 7;
   localparam int BYTE_W    = 8;
   localparam int SHIFT_W   = 16;
   localparam int WORD_W    = 9;
   localparam int REQ_DATA_W = 40;

   // Request kinds carried in tuser
   localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_FILL      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INIT      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REFRESH   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd4;

   // Sequence lengths
   localparam int INIT_CMD_COUNT  = 7;
   localparam int INIT_DATA_COUNT = 100;
   localparam int REF_CMD_COUNT   = 3;

   typedef struct packed {
      logic start_init;
      logic start_ref;
      logic tick;
   } seq_ctrl_type;

   typedef struct packed {
      logic active;
      logic need_read;
   } seq_stat_type;

   typedef struct packed {
      logic serial_bit;
      logic word_start;
      logic sequence_end;
   } rsp_bits_type;

   function automatic logic [BYTE_W-1:0] init_cmd(input logic [2:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'hE2;
         3'd1:    b = 8'hAF;
         3'd2:    b = 8'hA4;
         3'd3:    b = 8'h2F;
         3'd4:    b = 8'hB0;
         3'd5:    b = 8'h10;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] ref_cmd(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = 8'hB0;
         2'd1:    b = 8'h10;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/core/mono_lcd_framebuffer_refresher.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  tuser: cmd; tdata: pixel, fill and refresh fields
// rsp      out        rsp_tvalid/rsp_tready  tdata: serial bit; tuser: word start; tlast: end
// csr      in         csr_wr_en              csr_wr_data: invert
//
// A tick, init or set of a stored flag is done in the cycle it is taken; a tick that
// loads a refresh byte first reads the store, set pixel reads then writes the store and
// refresh waits while the column rotation is reduced one shift bit per cycle. Fill
// sweeps the store, and after reset the store is cleared by the same sweep before the
// first request is taken. A stalled result holds further requests only while the
// output register is full.

module mono_lcd_framebuffer_refresher
   import lcdfb_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF,
   parameter int PAGES   = PAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: pixel_x[6:0], pixel_y[13:7], pixel_on[14], fill_byte[22:15], shift[38:23]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: serial_bit[0]
   output logic [7:0]            rsp_tdata,
   // tuser: word_start[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CLW   = $clog2(COLUMNS);
   localparam int RYW   = $clog2(ROWS);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_FILL  = 6'b000100,
      ST_PIX   = 6'b001000,
      ST_MOD   = 6'b010000,
      ST_TICK  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      sweep_ff, sweep_in;
   logic [BYTE_W-1:0]  fill_ff, fill_in;
   logic [AW-1:0]      pix_idx_ff, pix_idx_in;
   logic [2:0]         pix_bit_ff, pix_bit_in;
   logic               pix_on_ff, pix_on_in;
   logic               invert_ff, invert_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_bits_type       rsp_bits_ff, rsp_bits_in;

   logic [COORD_W-1:0] px, py;
   logic [RYW-1:0]     pix_row, pix_page;
   logic [CLW-1:0]     pix_col;
   logic [AW-1:0]      pix_idx;
   logic               pix_ok;

   logic               req_fire;
   logic               produce;
   logic               mod_load;
   logic               mod_done;
   logic [CLW-1:0]     mod_rem;

   seq_ctrl_type       seq_ctrl;
   seq_stat_type       seq_stat;
   rsp_bits_type       seq_bits;
   logic [AW-1:0]      seq_rd_addr;

   logic               ram_we;
   logic [AW-1:0]      ram_wr_addr;
   logic [BYTE_W-1:0]  ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [BYTE_W-1:0]  ram_rd_data;
   logic [BYTE_W-1:0]  pix_mask;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Pixel (x,y) maps to page (ROWS-1-y)/8, bit (ROWS-1-y)%8, column (COLUMNS-x)%COLUMNS.
   always_comb begin
      px       = req_tdata[COORD_W-1:0];
      py       = req_tdata[2*COORD_W-1:COORD_W];
      pix_row  = RYW'(ROWS - 1) - RYW'(py);
      pix_page = pix_row >> 3;
      pix_col  = (px == '0) ? '0 : CLW'(32'(COLUMNS) - 32'(px));
      pix_idx  = AW'(32'(pix_page) * 32'(COLUMNS) + 32'(pix_col));
      pix_ok   = (32'(px) < 32'(COLUMNS)) && (32'(py) < 32'(ROWS))
                 && (32'(pix_page) < 32'(PAGES));
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fill_in      = fill_ff;
      pix_idx_in   = pix_idx_ff;
      pix_bit_in   = pix_bit_ff;
      pix_on_in    = pix_on_ff;
      invert_in    = csr_wr_en ? csr_wr_data : invert_ff;
      seq_ctrl     = '0;
      mod_load     = 1'b0;
      produce      = 1'b0;

      case (state_ff)
         ST_CLEAR, ST_FILL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  CMD_SET_PIXEL: begin
                     pix_idx_in = pix_idx;
                     pix_bit_in = pix_row[2:0];
                     pix_on_in  = req_tdata[2*COORD_W];
                     if (pix_ok) begin
                        state_in = ST_PIX;
                     end
                  end
                  CMD_FILL: begin
                     fill_in  = req_tdata[2*COORD_W+BYTE_W:2*COORD_W+1];
                     sweep_in = '0;
                     state_in = ST_FILL;
                  end
                  CMD_INIT: begin
                     seq_ctrl.start_init = !seq_stat.active;
                  end
                  CMD_REFRESH: begin
                     if (!seq_stat.active) begin
                        mod_load = 1'b1;
                        state_in = ST_MOD;
                     end
                  end
                  CMD_TICK: begin
                     if (seq_stat.active) begin
                        if (seq_stat.need_read) begin
                           state_in = ST_TICK;
                        end else begin
                           produce = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PIX: state_in = ST_IDLE;
         ST_MOD: begin
            if (mod_done) begin
               seq_ctrl.start_ref = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_TICK: begin
            produce  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      seq_ctrl.tick = produce;
   end

   // The output slot is always free when a result is produced.
   always_comb begin
      rsp_bits_in  = produce ? seq_bits : rsp_bits_ff;
      rsp_valid_in = produce || (rsp_valid_ff && !rsp_tready);
   end

   always_comb begin
      pix_mask    = 8'(1) << pix_bit_ff;
      ram_we      = 1'b0;
      ram_wr_addr = sweep_ff;
      ram_wr_data = '0;
      case (state_ff)
         ST_CLEAR: ram_we = 1'b1;
         ST_FILL: begin
            ram_we      = 1'b1;
            ram_wr_data = fill_ff;
         end
         ST_PIX: begin
            ram_we      = 1'b1;
            ram_wr_addr = pix_idx_ff;
            ram_wr_data = pix_on_ff ? (ram_rd_data | pix_mask) : (ram_rd_data & ~pix_mask);
         end
         default: ram_we = 1'b0;
      endcase
      ram_rd_addr = (req_tuser == CMD_SET_PIXEL) ? pix_idx : seq_rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         invert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         invert_ff    <= invert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_ff     <= fill_in;
      pix_idx_ff  <= pix_idx_in;
      pix_bit_ff  <= pix_bit_in;
      pix_on_ff   <= pix_on_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   lcdfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lcdfb_modred #(
      .COLUMNS (COLUMNS)
   ) u_modred (
      .clock     (clock),
      .reset     (reset),
      .load      (mod_load),
      .value     (req_tdata[2*COORD_W+BYTE_W+SHIFT_W:2*COORD_W+BYTE_W+1]),
      .remainder (mod_rem),
      .done      (mod_done)
   );

   lcdfb_seq #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (seq_ctrl),
      .rotation_new (mod_rem),
      .invert       (invert_ff),
      .store_byte   (ram_rd_data),
      .stat         (seq_stat),
      .rd_addr      (seq_rd_addr),
      .bits         (seq_bits)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_bits_ff.serial_bit};
   assign rsp_tuser  = rsp_bits_ff.word_start;
   assign rsp_tlast  = rsp_bits_ff.sequence_end;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during store clear");

   a_pix_one_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |=> (state_ff == ST_IDLE))
      else $error("set pixel did not finish in one write cycle");

   a_end_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (produce && seq_bits.sequence_end) |=> !seq_stat.active)
      else $error("sequence still running after its final bit");

   a_tick_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> !rsp_valid_ff)
      else $error("result produced while output register full");

endmodule

@@ rtl/core/lcdfb_ram.sv @@
`timescale 1ns / 1ps

module lcdfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 864
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lcdfb_modred.sv @@
`timescale 1ns / 1ps

module lcdfb_modred
   import lcdfb_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [SHIFT_W-1:0]         value,
   output logic [$clog2(COLUMNS)-1:0] remainder,
   output logic                       done
);

   localparam int CLW = $clog2(COLUMNS);
   localparam int CNW = $clog2(SHIFT_W);

   logic [SHIFT_W-1:0] shreg_ff, shreg_in;
   logic [CLW-1:0]     rem_ff, rem_in;
   logic [CNW-1:0]     cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CLW:0]       trial;

   // Restoring reduction, one bit of the value per cycle, most significant first.
   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shreg_ff[SHIFT_W-1]};
      if (trial >= (CLW+1)'(COLUMNS)) begin
         trial = trial - (CLW+1)'(COLUMNS);
      end
      if (load) begin
         shreg_in = value;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = trial[CLW-1:0];
         shreg_in = {shreg_ff[SHIFT_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNW'(SHIFT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

@@ rtl/core/lcdfb_seq.sv @@
`timescale 1ns / 1ps

module lcdfb_seq
   import lcdfb_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int PAGES   = PAGES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  seq_ctrl_type                       ctrl,
   input  logic [$clog2(COLUMNS)-1:0]         rotation_new,
   input  logic                               invert,
   input  logic [BYTE_W-1:0]                  store_byte,
   output seq_stat_type                       stat,
   output logic [$clog2(PAGES*COLUMNS)-1:0]   rd_addr,
   output rsp_bits_type                       bits
);

   localparam int CLW    = $clog2(COLUMNS);
   localparam int AW     = $clog2(PAGES*COLUMNS);
   localparam int MAXCNT = (COLUMNS > INIT_DATA_COUNT) ? COLUMNS : INIT_DATA_COUNT;
   localparam int CW     = $clog2(MAXCNT + 1);
   localparam int PW     = $clog2(PAGES + 1);

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_INIT_CMD  = 5'b00010,
      PH_INIT_DATA = 5'b00100,
      PH_REF_CMD   = 5'b01000,
      PH_REF_DATA  = 5'b10000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [PW-1:0]      page_ff, page_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   logic [WORD_W-1:0]  shifter_ff, shifter_in;
   logic [CLW-1:0]     rotation_ff, rotation_in;

   logic [WORD_W-1:0]  next_word;
   logic [WORD_W-1:0]  cur_word;
   logic [CW-1:0]      col_inc;
   logic [PW-1:0]      page_inc;
   logic               seq_end;
   logic [CLW:0]       col_sum;

   // Store address of the byte the current refresh word needs.
   always_comb begin
      col_sum = {1'b0, col_ff[CLW-1:0]} + {1'b0, rotation_ff};
      if (col_sum >= (CLW+1)'(COLUMNS)) begin
         col_sum = col_sum - (CLW+1)'(COLUMNS);
      end
      rd_addr = AW'(32'(page_ff) * 32'(COLUMNS) + 32'(col_sum));
   end

   always_comb begin
      case (phase_ff)
         PH_INIT_CMD: begin
            next_word = (col_ff < CW'(INIT_CMD_COUNT)) ? {1'b0, init_cmd(col_ff[2:0])} : '0;
         end
         PH_INIT_DATA: next_word = {1'b1, {BYTE_W{1'b0}}};
         PH_REF_CMD: begin
            next_word = (col_ff < CW'(REF_CMD_COUNT)) ? {1'b0, ref_cmd(col_ff[1:0])} : '0;
         end
         PH_REF_DATA:  next_word = {1'b1, invert ? ~store_byte : store_byte};
         default:      next_word = '0;
      endcase
      cur_word = (bit_cnt_ff == 4'd0) ? next_word : shifter_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      page_in     = page_ff;
      col_in      = col_ff;
      bit_cnt_in  = bit_cnt_ff;
      shifter_in  = shifter_ff;
      rotation_in = rotation_ff;
      col_inc     = col_ff + 1'b1;
      page_inc    = page_ff + 1'b1;
      seq_end     = 1'b0;

      if (ctrl.start_init || ctrl.start_ref) begin
         phase_in   = ctrl.start_init ? PH_INIT_CMD : PH_REF_CMD;
         page_in    = '0;
         col_in     = '0;
         bit_cnt_in = '0;
         shifter_in = '0;
         if (ctrl.start_ref) begin
            rotation_in = rotation_new;
         end
      end else if (ctrl.tick && phase_ff != PH_IDLE) begin
         shifter_in = {cur_word[WORD_W-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (bit_cnt_ff == 4'(WORD_W - 1)) begin
            bit_cnt_in = '0;
            col_in     = col_inc;
            case (phase_ff)
               PH_INIT_CMD: begin
                  if (col_inc >= CW'(INIT_CMD_COUNT)) begin
                     phase_in = PH_INIT_DATA;
                     col_in   = '0;
                  end
               end
               PH_INIT_DATA: begin
                  seq_end = (col_inc >= CW'(INIT_DATA_COUNT));
               end
               PH_REF_CMD: begin
                  if (col_inc >= CW'(REF_CMD_COUNT)) begin
                     phase_in = PH_REF_DATA;
                     col_in   = '0;
                     page_in  = '0;
                  end
               end
               PH_REF_DATA: begin
                  if (col_inc >= CW'(COLUMNS)) begin
                     col_in  = '0;
                     page_in = page_inc;
                     seq_end = (page_inc >= PW'(PAGES));
                  end
               end
               default: seq_end = 1'b1;
            endcase
            if (seq_end) begin
               phase_in = PH_IDLE;
               page_in  = '0;
               col_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         page_ff     <= '0;
         col_ff      <= '0;
         bit_cnt_ff  <= '0;
         shifter_ff  <= '0;
         rotation_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         page_ff     <= page_in;
         col_ff      <= col_in;
         bit_cnt_ff  <= bit_cnt_in;
         shifter_ff  <= shifter_in;
         rotation_ff <= rotation_in;
      end
   end

   assign stat.active       = (phase_ff != PH_IDLE);
   assign stat.need_read    = (phase_ff == PH_REF_DATA) && (bit_cnt_ff == 4'd0);
   assign bits.serial_bit   = cur_word[WORD_W-1];
   assign bits.word_start   = (bit_cnt_ff == 4'd0);
   assign bits.sequence_end = seq_end;

endmodule

@@ bench/lcd_serial_checker.sv @@
`timescale 1ns / 1ps

module lcd_serial_checker
   import lcdfb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // tdata: pixel_x[6:0], pixel_y[13:7], pixel_on[14], fill_byte[22:15], shift[38:23]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: serial_bit[0]
   input  logic [7:0]            rsp_tdata,
   // tuser: word_start[0]
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   output int                    fail_count,
   output int                    pending,
   output logic                  seq_busy
);

   localparam int STORE_DEPTH = PAGES_DEF * COLUMNS_DEF;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INIT_CMDS,
      SEQ_INIT_DATA,
      SEQ_REF_CMDS,
      SEQ_REF_DATA
   } seq_phase_type;

   logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
   seq_phase_type     phase;
   logic [3:0]        page_idx;
   logic [6:0]        word_idx;
   logic [3:0]        bits_sent;
   logic [WORD_W-1:0] out_word;
   logic [6:0]        rotation;
   logic              invert;
   rsp_bits_type      bits_due [$];
   int                errors = 0;

   // The refresh command bytes are the last three of the init commands.
   function automatic logic [BYTE_W-1:0] command_byte(input int pos);
      logic [BYTE_W-1:0] b;
      case (pos)
         0:       b = 8'hE2;
         1:       b = 8'hAF;
         2:       b = 8'hA4;
         3:       b = 8'h2F;
         4:       b = 8'hB0;
         5:       b = 8'h10;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // A refresh byte is taken from the store at the moment its flag bit goes out.
   function automatic logic [WORD_W-1:0] next_word();
      int                addr;
      logic [BYTE_W-1:0] b;
      logic [WORD_W-1:0] w;
      case (phase)
         SEQ_INIT_CMDS: w = {1'b0, command_byte(int'(word_idx))};
         SEQ_INIT_DATA: w = 9'h100;
         SEQ_REF_CMDS:  w = {1'b0, command_byte(int'(word_idx) + 4)};
         SEQ_REF_DATA: begin
            addr = int'(page_idx) * COLUMNS_DEF
                   + (int'(word_idx) + int'(rotation)) % COLUMNS_DEF;
            b = shadow_store[addr];
            w = {1'b1, invert ? ~b : b};
         end
         default: w = '0;
      endcase
      return w;
   endfunction

   task automatic begin_sequence(input seq_phase_type next_phase);
      phase     = next_phase;
      page_idx  = '0;
      word_idx  = '0;
      bits_sent = '0;
      out_word  = '0;
   endtask

   task automatic emit_bit();
      rsp_bits_type due;
      due.word_start   = 1'b0;
      due.sequence_end = 1'b0;
      if (bits_sent == 4'd0) begin
         out_word = next_word();
         due.word_start = 1'b1;
      end
      due.serial_bit = out_word[WORD_W-1];
      out_word = {out_word[WORD_W-2:0], 1'b0};
      bits_sent++;
      if (bits_sent == 4'(WORD_W)) begin
         bits_sent = '0;
         word_idx++;
         case (phase)
            SEQ_INIT_CMDS: begin
               if (word_idx == INIT_CMD_COUNT) begin
                  phase    = SEQ_INIT_DATA;
                  word_idx = '0;
               end
            end
            SEQ_INIT_DATA: begin
               if (word_idx == INIT_DATA_COUNT) due.sequence_end = 1'b1;
            end
            SEQ_REF_CMDS: begin
               if (word_idx == REF_CMD_COUNT) begin
                  phase    = SEQ_REF_DATA;
                  word_idx = '0;
                  page_idx = '0;
               end
            end
            SEQ_REF_DATA: begin
               if (word_idx == COLUMNS_DEF) begin
                  word_idx = '0;
                  page_idx++;
                  if (page_idx == PAGES_DEF) due.sequence_end = 1'b1;
               end
            end
            default: ;
         endcase
         if (due.sequence_end) begin_sequence(SEQ_IDLE);
      end
      bits_due.push_back(due);
   endtask

   task automatic take_request(input logic [CMD_W-1:0] kind,
                               input logic [REQ_DATA_W-1:0] data);
      logic [6:0]  px;
      logic [6:0]  py;
      logic [15:0] sh;
      int          row;
      int          addr;
      px = data[6:0];
      py = data[13:7];
      sh = data[38:23];
      case (kind)
         CMD_SET_PIXEL: begin
            // Rows are counted from the bottom and columns mirrored on the panel.
            if (px < COLUMNS_DEF && py < ROWS_DEF) begin
               row  = ROWS_DEF - 1 - int'(py);
               addr = (row / 8) * COLUMNS_DEF + (COLUMNS_DEF - int'(px)) % COLUMNS_DEF;
               if (row / 8 < PAGES_DEF) shadow_store[addr][row % 8] = data[14];
            end
         end
         CMD_FILL: begin
            foreach (shadow_store[i]) shadow_store[i] = data[22:15];
         end
         CMD_INIT: begin
            if (phase == SEQ_IDLE) begin_sequence(SEQ_INIT_CMDS);
         end
         CMD_REFRESH: begin
            if (phase == SEQ_IDLE) begin
               begin_sequence(SEQ_REF_CMDS);
               rotation = 7'(int'(sh) % COLUMNS_DEF);
            end
         end
         CMD_TICK: begin
            if (phase != SEQ_IDLE) emit_bit();
         end
         default: ;
      endcase
   endtask

   task automatic check_response();
      rsp_bits_type want;
      if (bits_due.size() == 0) begin
         $error("response with nothing due: serial_bit %0d, word_start %0d, sequence_end %0d",
                rsp_tdata[0], rsp_tuser, rsp_tlast);
         errors++;
      end else begin
         want = bits_due.pop_front();
         if (rsp_tdata[0] !== want.serial_bit) begin
            $error("serial_bit: expected %0d, got %0d", want.serial_bit, rsp_tdata[0]);
            errors++;
         end
         if (rsp_tuser !== want.word_start) begin
            $error("word_start: expected %0d, got %0d", want.word_start, rsp_tuser);
            errors++;
         end
         if (rsp_tlast !== want.sequence_end) begin
            $error("sequence_end: expected %0d, got %0d", want.sequence_end, rsp_tlast);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_store[i]) shadow_store[i] = '0;
         begin_sequence(SEQ_IDLE);
         rotation = '0;
         invert   = 1'b0;
         bits_due.delete();
      end else begin
         if (csr_wr_en) invert = csr_wr_data;
         if (req_tvalid && req_tready) take_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_response();
      end
      fail_count <= errors;
      pending    <= bits_due.size();
      seq_busy   <= (phase != SEQ_IDLE);
   end

endmodule

@@ bench/tb_mono_lcd_framebuffer_refresher.sv @@
`timescale 1ns / 1ps

module tb_mono_lcd_framebuffer_refresher;
   import lcdfb_pkg::*;

   localparam int ITEM_COUNT     = 1850;
   // Requests of the directed part, the ticks that run the init sequence out included.
   localparam int DIRECTED_ITEMS = 1185;
   localparam int RANDOM_PHASES  = 3;
   localparam int FLUSH_CYCLES   = 1000;
   localparam int CYCLE_LIMIT    = 10_000_000;

   localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_TICK + 3'd1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic                  csr_wr_data;
   int                    fail_count;
   int                    pending;
   logic                  seq_busy;
   int                    cycle_count = 0;
   int                    req_calm = 0;
   int                    rsp_calm = 0;
   int                    rsp_hold = 0;

   mono_lcd_framebuffer_refresher u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lcd_serial_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .seq_busy    (seq_busy)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 24);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else begin
         rsp_hold = idle_len();
         if ($urandom_range(0, 199) == 0) rsp_calm = $urandom_range(50, 300);
         rsp_tready <= (rsp_hold == 0);
         if (rsp_hold > 0) rsp_hold--;
      end
   end

   // Valid stays high straight into the next request when no gap is drawn.
   task automatic send_request(input logic [CMD_W-1:0] kind, input logic [6:0] x,
                               input logic [6:0] y, input logic on,
                               input logic [7:0] fill, input logic [15:0] shift);
      int gap;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, shift, fill, on, y, x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (req_calm > 0) begin
         req_calm--;
         gap = 0;
      end else begin
         gap = idle_len();
         if ($urandom_range(0, 199) == 0) req_calm = $urandom_range(50, 300);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      send_request(CMD_TICK, 7'($urandom), 7'($urandom), 1'($urandom),
                   8'($urandom), 16'($urandom));
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Ticks a running sequence to its end, then lets a fill sweep finish as well.
   task automatic finish_sequence();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (seq_busy) send_tick();
      wait_results();
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   // Drains every result and lets a fill sweep run out; a running sequence stays put.
   task automatic settle();
      wait_results();
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_invert(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_requests(input int count);
      int               taken;
      int               r;
      logic [CMD_W-1:0] kind;
      logic [6:0]       x;
      logic [6:0]       y;
      taken = 0;
      while (taken < count) begin
         r = $urandom_range(0, 99);
         if (r < 68) kind = CMD_TICK;
         else if (r < 84) kind = CMD_SET_PIXEL;
         else if (r < 86) kind = CMD_FILL;
         else if (r < 91) kind = CMD_INIT;
         else if (r < 96) kind = CMD_REFRESH;
         else kind = CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 2));
         x = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, COLUMNS_DEF - 1))
                                          : 7'($urandom);
         y = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, ROWS_DEF - 1))
                                          : 7'($urandom);
         taken++;
         if ($urandom_range(0, 299) == 0) wait_results();
         send_request(kind, x, y, 1'($urandom), 8'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      int k;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_TICK;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_invert(1'b0);

      send_tick();
      for (k = 0; k < 3; k++) begin
         send_request(CMD_FIRST_UNUSED + CMD_W'(k), '1, '1, 1'b1, '1, '1);
      end
      send_request(CMD_FILL, '0, '0, 1'b0, 8'hFF, '0);
      send_request(CMD_FILL, '1, '1, 1'b1, 8'h00, '1);
      send_request(CMD_SET_PIXEL, 7'd0, 7'd0, 1'b1, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd95, 7'd67, 1'b1, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd0, 7'd67, 1'b1, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd95, 7'd0, 1'b1, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd95, 7'd0, 1'b0, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd127, 7'd127, 1'b1, '1, '1);
      send_request(CMD_SET_PIXEL, 7'd96, 7'd5, 1'b1, '0, '0);
      send_request(CMD_SET_PIXEL, 7'd5, 7'd68, 1'b1, '0, '0);
      send_request(CMD_INIT, '0, '0, 1'b0, '0, '0);
      send_request(CMD_INIT, '0, '0, 1'b0, '0, '0);
      send_request(CMD_REFRESH, '0, '0, 1'b0, '0, 16'hFFFF);
      finish_sequence();

      // Store updates while a refresh is part way through page zero.
      send_request(CMD_REFRESH, '0, '0, 1'b0, '0, 16'hFFFF);
      repeat (200) send_tick();
      send_request(CMD_SET_PIXEL, 7'd5, 7'd60, 1'b1, '0, '0);
      send_request(CMD_FILL, '0, '0, 1'b0, 8'h3C, '0);
      send_request(CMD_SET_PIXEL, 7'd4, 7'd60, 1'b0, '0, '0);
      settle();
      write_invert(1'b1);

      // The refresh keeps running, so invert changes land between its data bytes.
      for (k = 0; k < RANDOM_PHASES; k++) begin
         random_requests((ITEM_COUNT - DIRECTED_ITEMS) / RANDOM_PHASES);
         settle();
         if (k < RANDOM_PHASES - 1) write_invert(k[0]);
      end

      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lcdfb_pkg.sv
rtl/core/lcdfb_ram.sv
rtl/core/lcdfb_modred.sv
rtl/core/lcdfb_seq.sv
rtl/core/mono_lcd_framebuffer_refresher.sv
bench/lcd_serial_checker.sv
bench/tb_mono_lcd_framebuffer_refresher.sv
